// File: hdl/dll_pkg.sv
// Shared types and codes for the doubly linked list engine.
package dll_pkg;

    localparam int CMD_W  = 3;
    localparam int POS_W  = 7;
    localparam int LEN_W  = 7;
    localparam int WORD_W = 32;
    localparam int STAT_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_INS_HEAD = 3'd0,
        CMD_INS_TAIL = 3'd1,
        CMD_INS_POS  = 3'd2,
        CMD_DEL_POS  = 3'd3,
        CMD_READ_POS = 3'd4
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_RANGE = 2'd2,
        STAT_EMPTY = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        OP_HEAD,
        OP_TAIL,
        OP_MID,
        OP_DEL,
        OP_READ
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TAKE,
        S_WALK,
        S_WB1,
        S_WB2,
        S_DONE
    } state_t;

endpackage

// File: hdl/doubly_linked_list_engine_core.sv
// Doubly linked list engine: node pool, free list and command sequencer.
//
// Issue a command with start while busy is low; busy stays high until the
// result word has been presented, and done marks the single cycle in which
// status, read_value, list_length, head_value and tail_value are valid. The
// receiver cannot stall, so the result word must be taken in that cycle.
// Rejected and unknown commands go straight to the done state. Head and tail
// inserts take a pool entry and write links in WB1 and WB2; read walks to
// position p; delete walks there and passes WB1 and WB2; insert at p takes
// an entry, walks to the node before p and passes WB1 and WB2. The walk
// follows one next link per cycle through the single link-memory read port.
// No clearing pass is needed after reset: a fill mark tracks entries never used.
module doubly_linked_list_engine_core #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [dll_pkg::CMD_W-1:0]         cmd,
    input  logic [dll_pkg::POS_W-1:0]         position,
    input  logic signed [dll_pkg::WORD_W-1:0] value,
    output logic                              done,
    output logic [dll_pkg::STAT_W-1:0]        status,
    output logic signed [dll_pkg::WORD_W-1:0] read_value,
    output logic [dll_pkg::LEN_W-1:0]         list_length,
    output logic signed [dll_pkg::WORD_W-1:0] head_value,
    output logic signed [dll_pkg::WORD_W-1:0] tail_value
);
    import dll_pkg::*;

    localparam int IW = $clog2(CAPACITY + 1);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int PW = (IW > POS_W) ? IW : POS_W;
    localparam logic [IW-1:0] NIL = IW'(CAPACITY);

    logic [DATA_WIDTH-1:0] val_mem [CAPACITY];
    logic [IW-1:0]         nxt_mem [CAPACITY];
    logic [IW-1:0]         prv_mem [CAPACITY];

    state_t                state_reg, state_next;
    op_t                   op_reg, op_next;
    status_t               stat_reg, stat_next;
    logic [PW-1:0]         pos_reg, pos_next;
    logic [DATA_WIDTH-1:0] val_reg, val_next;
    logic [DATA_WIDTH-1:0] rv_reg, rv_next;
    logic [IW-1:0]         first_reg, first_next;
    logic [IW-1:0]         last_reg, last_next;
    logic [IW-1:0]         free_reg, free_next;
    logic [IW-1:0]         fill_reg, fill_next;
    logic [IW-1:0]         count_reg, count_next;
    logic [IW-1:0]         cur_reg, cur_next;
    logic [IW-1:0]         new_reg, new_next;
    logic [PW-1:0]         rem_reg, rem_next;
    logic [DATA_WIDTH-1:0] hval_reg, hval_next;
    logic [DATA_WIDTH-1:0] tval_reg, tval_next;
    logic                  hfix_reg, hfix_next;
    logic                  tfix_reg, tfix_next;

    logic                  done_reg, done_next;
    logic [STAT_W-1:0]     ostat_reg, ostat_next;
    logic [WORD_W-1:0]     orv_reg, orv_next;
    logic [LEN_W-1:0]      olen_reg, olen_next;
    logic [WORD_W-1:0]     ohead_reg, ohead_next;
    logic [WORD_W-1:0]     otail_reg, otail_next;

    logic                  rd_en;
    logic [IW-1:0]         rd_addr;
    logic [DATA_WIDTH-1:0] rd_val_q;
    logic [IW-1:0]         rd_nxt_q;
    logic [IW-1:0]         rd_prv_q;

    logic                  val_we;
    logic [IW-1:0]         val_wa;
    logic [DATA_WIDTH-1:0] val_wd;
    logic                  nxt_we;
    logic [IW-1:0]         nxt_wa;
    logic [IW-1:0]         nxt_wd;
    logic                  prv_we;
    logic [IW-1:0]         prv_wa;
    logic [IW-1:0]         prv_wd;

    logic [PW-1:0]         posx;
    logic [PW-1:0]         cntx;

    assign posx = PW'(position);
    assign cntx = PW'(count_reg);

    always_ff @(posedge clk)
    begin
        if (val_we)
        begin
            val_mem[val_wa[AW-1:0]] <= val_wd;
        end
        if (nxt_we)
        begin
            nxt_mem[nxt_wa[AW-1:0]] <= nxt_wd;
        end
        if (prv_we)
        begin
            prv_mem[prv_wa[AW-1:0]] <= prv_wd;
        end
        if (rd_en)
        begin
            rd_val_q <= val_mem[rd_addr[AW-1:0]];
            rd_nxt_q <= nxt_mem[rd_addr[AW-1:0]];
            rd_prv_q <= prv_mem[rd_addr[AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            first_reg <= NIL;
            last_reg  <= NIL;
            free_reg  <= '0;
            fill_reg  <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            first_reg <= first_next;
            last_reg  <= last_next;
            free_reg  <= free_next;
            fill_reg  <= fill_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        stat_reg  <= stat_next;
        pos_reg   <= pos_next;
        val_reg   <= val_next;
        rv_reg    <= rv_next;
        cur_reg   <= cur_next;
        new_reg   <= new_next;
        rem_reg   <= rem_next;
        hval_reg  <= hval_next;
        tval_reg  <= tval_next;
        hfix_reg  <= hfix_next;
        tfix_reg  <= tfix_next;
        ostat_reg <= ostat_next;
        orv_reg   <= orv_next;
        olen_reg  <= olen_next;
        ohead_reg <= ohead_next;
        otail_reg <= otail_next;
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        stat_next  = stat_reg;
        pos_next   = pos_reg;
        val_next   = val_reg;
        rv_next    = rv_reg;
        first_next = first_reg;
        last_next  = last_reg;
        free_next  = free_reg;
        fill_next  = fill_reg;
        count_next = count_reg;
        cur_next   = cur_reg;
        new_next   = new_reg;
        rem_next   = rem_reg;
        hval_next  = hval_reg;
        tval_next  = tval_reg;
        hfix_next  = hfix_reg;
        tfix_next  = tfix_reg;
        done_next  = 1'b0;
        ostat_next = ostat_reg;
        orv_next   = orv_reg;
        olen_next  = olen_reg;
        ohead_next = ohead_reg;
        otail_next = otail_reg;
        rd_en      = 1'b0;
        rd_addr    = first_reg;
        val_we     = 1'b0;
        val_wa     = new_reg;
        val_wd     = val_reg;
        nxt_we     = 1'b0;
        nxt_wa     = new_reg;
        nxt_wd     = NIL;
        prv_we     = 1'b0;
        prv_wa     = new_reg;
        prv_wd     = NIL;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    stat_next = STAT_OK;
                    rv_next   = '0;
                    pos_next  = posx;
                    val_next  = DATA_WIDTH'($unsigned(value));
                    cur_next  = first_reg;
                    priority if (cmd == CMD_INS_HEAD || cmd == CMD_INS_TAIL ||
                                 cmd == CMD_INS_POS)
                    begin
                        priority if (count_reg == NIL)
                        begin
                            stat_next  = STAT_FULL;
                            state_next = S_DONE;
                        end
                        else if (cmd == CMD_INS_POS &&
                                 (posx == '0 || posx > cntx + PW'(1)))
                        begin
                            stat_next  = STAT_RANGE;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            priority if (cmd == CMD_INS_HEAD ||
                                         (cmd == CMD_INS_POS && posx == PW'(1)))
                            begin
                                op_next = OP_HEAD;
                            end
                            else if (cmd == CMD_INS_TAIL || posx == cntx + PW'(1))
                            begin
                                op_next = OP_TAIL;
                            end
                            else
                            begin
                                op_next = OP_MID;
                            end
                            rd_en      = 1'b1;
                            rd_addr    = free_reg;
                            state_next = S_TAKE;
                        end
                    end
                    else if (cmd == CMD_DEL_POS || cmd == CMD_READ_POS)
                    begin
                        priority if (count_reg == '0)
                        begin
                            stat_next  = STAT_EMPTY;
                            state_next = S_DONE;
                        end
                        else if (posx == '0 || posx > cntx)
                        begin
                            stat_next  = STAT_RANGE;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            op_next    = (cmd == CMD_DEL_POS) ? OP_DEL : OP_READ;
                            rd_en      = 1'b1;
                            rd_addr    = first_reg;
                            rem_next   = posx - PW'(1);
                            state_next = S_WALK;
                        end
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end

            S_TAKE:
            begin
                new_next = free_reg;
                if (free_reg == fill_reg)
                begin
                    free_next = free_reg + IW'(1);
                    fill_next = fill_reg + IW'(1);
                end
                else
                begin
                    free_next = rd_nxt_q;
                end
                if (op_reg == OP_MID)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = first_reg;
                    cur_next   = first_reg;
                    rem_next   = pos_reg - PW'(2);
                    state_next = S_WALK;
                end
                else
                begin
                    state_next = S_WB1;
                end
            end

            S_WALK:
            begin
                if (rem_reg == '0)
                begin
                    if (op_reg == OP_READ)
                    begin
                        rv_next    = rd_val_q;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_WB1;
                    end
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = rd_nxt_q;
                    cur_next = rd_nxt_q;
                    rem_next = rem_reg - PW'(1);
                end
            end

            S_WB1:
            begin
                state_next = S_WB2;
                unique case (op_reg)
                    OP_HEAD:
                    begin
                        val_we = 1'b1;
                        nxt_we = 1'b1;
                        nxt_wd = first_reg;
                        prv_we = 1'b1;
                    end
                    OP_TAIL:
                    begin
                        val_we = 1'b1;
                        nxt_we = 1'b1;
                        prv_we = 1'b1;
                        prv_wd = last_reg;
                    end
                    OP_MID:
                    begin
                        val_we = 1'b1;
                        nxt_we = 1'b1;
                        nxt_wd = rd_nxt_q;
                        prv_we = 1'b1;
                        prv_wd = cur_reg;
                    end
                    OP_DEL:
                    begin
                        rv_next   = rd_val_q;
                        hfix_next = (rd_prv_q == NIL) && (rd_nxt_q != NIL);
                        tfix_next = (rd_nxt_q == NIL) && (rd_prv_q != NIL);
                        if (rd_prv_q != NIL)
                        begin
                            nxt_we = 1'b1;
                            nxt_wa = rd_prv_q;
                            nxt_wd = rd_nxt_q;
                        end
                        else
                        begin
                            first_next = rd_nxt_q;
                        end
                        if (rd_nxt_q != NIL)
                        begin
                            prv_we = 1'b1;
                            prv_wa = rd_nxt_q;
                            prv_wd = rd_prv_q;
                        end
                        else
                        begin
                            last_next = rd_prv_q;
                        end
                        if (rd_prv_q == NIL && rd_nxt_q != NIL)
                        begin
                            rd_en   = 1'b1;
                            rd_addr = rd_nxt_q;
                        end
                        else if (rd_nxt_q == NIL && rd_prv_q != NIL)
                        begin
                            rd_en   = 1'b1;
                            rd_addr = rd_prv_q;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            S_WB2:
            begin
                state_next = S_DONE;
                unique case (op_reg)
                    OP_HEAD:
                    begin
                        if (first_reg != NIL)
                        begin
                            prv_we = 1'b1;
                            prv_wa = first_reg;
                            prv_wd = new_reg;
                        end
                        else
                        begin
                            last_next = new_reg;
                            tval_next = val_reg;
                        end
                        first_next = new_reg;
                        hval_next  = val_reg;
                        count_next = count_reg + IW'(1);
                    end
                    OP_TAIL:
                    begin
                        if (last_reg != NIL)
                        begin
                            nxt_we = 1'b1;
                            nxt_wa = last_reg;
                            nxt_wd = new_reg;
                        end
                        else
                        begin
                            first_next = new_reg;
                            hval_next  = val_reg;
                        end
                        last_next  = new_reg;
                        tval_next  = val_reg;
                        count_next = count_reg + IW'(1);
                    end
                    OP_MID:
                    begin
                        prv_we     = 1'b1;
                        prv_wa     = rd_nxt_q;
                        prv_wd     = new_reg;
                        nxt_we     = 1'b1;
                        nxt_wa     = cur_reg;
                        nxt_wd     = new_reg;
                        count_next = count_reg + IW'(1);
                    end
                    OP_DEL:
                    begin
                        nxt_we     = 1'b1;
                        nxt_wa     = cur_reg;
                        nxt_wd     = free_reg;
                        prv_we     = 1'b1;
                        prv_wa     = cur_reg;
                        free_next  = cur_reg;
                        count_next = count_reg - IW'(1);
                        if (hfix_reg)
                        begin
                            hval_next = rd_val_q;
                        end
                        if (tfix_reg)
                        begin
                            tval_next = rd_val_q;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            S_DONE:
            begin
                done_next  = 1'b1;
                ostat_next = stat_reg;
                orv_next   = WORD_W'(rv_reg);
                olen_next  = LEN_W'(count_reg);
                ohead_next = (first_reg == NIL) ? '0 : WORD_W'(hval_reg);
                otail_next = (last_reg == NIL) ? '0 : WORD_W'(tval_reg);
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign status      = ostat_reg;
    assign read_value  = ostat_reg == STAT_OK ? orv_reg : '0;
    assign list_length = olen_reg;
    assign head_value  = ohead_reg;
    assign tail_value  = otail_reg;

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result word strobed on two cycles in a row");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= NIL)
        else $error("node count above pool capacity");

    a_empty_links: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |->
            (((first_reg == NIL) == (count_reg == '0)) &&
             ((last_reg == NIL) == (count_reg == '0))))
        else $error("head or tail link disagrees with node count");

endmodule
